### design/dpu_pkg.sv
// Shared types, constants and helper functions for the dynamic priority update block.
package dpu_pkg;

  localparam int unsigned SpriW  = 8;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CountW = 16;
  localparam int unsigned QuantW = 12;
  localparam int unsigned BonusW = 4;
  localparam int unsigned DivW   = CountW + 1;
  localparam int unsigned RemW   = DivW;
  localparam int unsigned ProdW  = TimeW + CountW;
  localparam int unsigned InW    = SpriW + 3 * TimeW + CountW;
  localparam int unsigned OutW   = QuantW + TimeW + CountW + BonusW + SpriW;

  localparam logic [SpriW-1:0]  SpriEnd     = 8'd140;
  localparam logic [SpriW-1:0]  SpriSplit   = 8'd120;
  localparam logic [SpriW-1:0]  PrioMin     = 8'd100;
  localparam logic [SpriW-1:0]  PrioMax     = 8'd139;
  localparam logic [BonusW-1:0] BonusMax    = 4'd10;
  localparam logic [TimeW-1:0]  BracketW    = 32'd100;
  localparam logic [TimeW-1:0]  BonusCapAvg = 32'd1000;

  typedef struct packed {
    logic [RemW-1:0]   rem;
    logic [TimeW-1:0]  num;
    logic [TimeW-1:0]  quot;
    logic [DivW-1:0]   divisor;
    logic [QuantW-1:0] quantum;
    logic [CountW-1:0] new_n;
    logic [SpriW-1:0]  spri;
  } dpu_stage_t;

  function automatic logic [QuantW-1:0] quantum_of(input logic [SpriW-1:0] s);
    logic [SpriW-1:0] diff;
    diff = SpriEnd - s;
    if (s >= SpriEnd) begin
      quantum_of = '0;
    end else if (s < SpriSplit) begin
      quantum_of = QuantW'({4'd0, diff} * 12'd20);
    end else begin
      quantum_of = QuantW'({4'd0, diff} * 12'd5);
    end
  endfunction

  function automatic logic [BonusW-1:0] bonus_of(input logic [TimeW-1:0] avg);
    logic [BonusW-1:0] b;
    b = '0;
    if (avg >= BonusCapAvg) begin
      b = BonusMax;
    end else begin
      for (int k = 1; k < 10; k++) begin
        if (avg >= BracketW * TimeW'(k)) b = BonusW'(k);
      end
    end
    bonus_of = b;
  endfunction

  function automatic logic [SpriW-1:0] prio_of(input logic [SpriW-1:0] s,
                                               input logic [BonusW-1:0] b);
    logic signed [SpriW+1:0] t;
    t = $signed({2'b00, s}) - $signed({6'd0, b}) + 10'sd5;
    if (t < $signed({2'b00, PrioMin})) begin
      prio_of = PrioMin;
    end else if (t > $signed({2'b00, PrioMax})) begin
      prio_of = PrioMax;
    end else begin
      prio_of = t[SpriW-1:0];
    end
  endfunction

endpackage

### design/dpu_div_cell.sv
// One restoring division cell: retires one quotient bit and passes the record on.
module dpu_div_cell
  import dpu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  dpu_stage_t stage_i,
  output logic       valid_o,
  output dpu_stage_t stage_o
);

  logic       valid_q;
  dpu_stage_t stage_q, stage_d;
  logic [RemW:0] shifted;
  logic [RemW:0] diff;
  logic          take;

  always_comb begin
    shifted = {stage_i.rem, stage_i.num[TimeW-1]};
    diff    = shifted - {1'b0, stage_i.divisor};
    take    = shifted >= {1'b0, stage_i.divisor};
    stage_d      = stage_i;
    stage_d.rem  = take ? diff[RemW-1:0] : shifted[RemW-1:0];
    stage_d.num  = {stage_i.num[TimeW-2:0], 1'b0};
    stage_d.quot = {stage_i.quot[TimeW-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

### design/dynamic_priority_update.sv
// Top level: dynamic priority and sleep average update, one process record per beat.
//
//  channel  | dir | beat contents (tdata, lowest bits first)
//  s_axis   | in  | static_priority[7:0] average_sleep[39:8] sleep_samples[55:40]
//           |     | last_run_time[87:56] current_time[119:88]
//  m_axis   | out | time_quantum[11:0] new_average_sleep[43:12] new_sleep_samples[59:44]
//           |     | sleep_bonus[63:60] dynamic_priority[71:64]
//
// One beat per cycle sustained while the output is not stalled. The pipeline is the multiply
// and sum registers, the 32-cell division chain (one quotient bit per cell) and the output
// register. Reset clears all valid flags only.
// A stalled output freezes the whole chain; one input beat more is caught in a skid register.
module dynamic_priority_update
  import dpu_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  // static_priority, average_sleep, sleep_samples, last_run_time, current_time
  input  logic [InW-1:0]  s_axis_tdata_i,
  output logic            m_axis_tvalid_o,
  input  logic            m_axis_tready_i,
  // time_quantum, new_average_sleep, new_sleep_samples, sleep_bonus, dynamic_priority
  output logic [OutW-1:0] m_axis_tdata_o
);

  logic            adv;
  logic            skid_valid_q;
  logic [InW-1:0]  skid_q;
  logic            in_valid;
  logic [InW-1:0]  in_data;

  logic [SpriW-1:0]  in_spri;
  logic [TimeW-1:0]  in_avg;
  logic [CountW-1:0] in_n;
  logic [TimeW-1:0]  in_last;
  logic [TimeW-1:0]  in_now;

  logic              p_valid_q;
  logic [ProdW-1:0]  p_prod_q;
  logic [TimeW-1:0]  p_elapsed_q;
  logic [DivW-1:0]   p_div_q;
  logic [QuantW-1:0] p_quant_q;
  logic [CountW-1:0] p_new_n_q;
  logic [SpriW-1:0]  p_spri_q;

  logic              s_valid_q;
  dpu_stage_t        s_stage_q, s_stage_d;
  logic [ProdW-1:0]  dividend;

  logic              cell_valid [0:TimeW];
  dpu_stage_t        cell_stage [0:TimeW];

  logic              out_valid_q;
  logic [OutW-1:0]   out_data_q, out_data_d;
  logic [BonusW-1:0] fin_bonus;
  dpu_stage_t        fin;

  assign adv             = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !skid_valid_q;
  assign in_valid        = skid_valid_q || s_axis_tvalid_i;
  assign in_data         = skid_valid_q ? skid_q : s_axis_tdata_i;

  assign in_spri = in_data[SpriW-1:0];
  assign in_avg  = in_data[SpriW +: TimeW];
  assign in_n    = in_data[SpriW+TimeW +: CountW];
  assign in_last = in_data[SpriW+TimeW+CountW +: TimeW];
  assign in_now  = in_data[SpriW+2*TimeW+CountW +: TimeW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_valid_q <= 1'b0;
    end else if (adv) begin
      skid_valid_q <= 1'b0;
    end else if (s_axis_tvalid_i && s_axis_tready_o) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!adv && s_axis_tvalid_i && s_axis_tready_o) begin
      skid_q <= s_axis_tdata_i;
    end
  end

  // multiply stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      s_valid_q <= 1'b0;
    end else if (adv) begin
      p_valid_q <= in_valid;
      s_valid_q <= p_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_prod_q    <= {{CountW{1'b0}}, in_avg} * {{TimeW{1'b0}}, in_n};
      p_elapsed_q <= in_now - in_last;
      p_div_q     <= {1'b0, in_n} + DivW'(1);
      p_quant_q   <= quantum_of(in_spri);
      p_new_n_q   <= (in_n == {CountW{1'b1}}) ? in_n : in_n + CountW'(1);
      p_spri_q    <= in_spri;
    end
  end

  // sum stage; quotient fits 32 bits, so the top half is already below the divisor
  assign dividend = p_prod_q + {{CountW{1'b0}}, p_elapsed_q};

  always_comb begin
    s_stage_d.rem     = {1'b0, dividend[ProdW-1:TimeW]};
    s_stage_d.num     = dividend[TimeW-1:0];
    s_stage_d.quot    = '0;
    s_stage_d.divisor = p_div_q;
    s_stage_d.quantum = p_quant_q;
    s_stage_d.new_n   = p_new_n_q;
    s_stage_d.spri    = p_spri_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s_stage_q <= s_stage_d;
    end
  end

  assign cell_valid[0] = s_valid_q;
  assign cell_stage[0] = s_stage_q;

  for (genvar g = 0; g < TimeW; g++) begin : g_cell
    dpu_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (cell_valid[g]),
      .stage_i (cell_stage[g]),
      .valid_o (cell_valid[g+1]),
      .stage_o (cell_stage[g+1])
    );
  end

  assign fin       = cell_stage[TimeW];
  assign fin_bonus = bonus_of(fin.quot);
  assign out_data_d = {prio_of(fin.spri, fin_bonus), fin_bonus, fin.new_n, fin.quot,
                       fin.quantum};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= cell_valid[TimeW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

### design/dpu_checker.sv
// Port-level checks for the dynamic priority update block, bound to the top level.
module dpu_checker
  import dpu_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            s_axis_tready_o,
  input logic            m_axis_tvalid_o,
  input logic            m_axis_tready_i,
  input logic [OutW-1:0] m_axis_tdata_o
);

  logic [BonusW-1:0] o_bonus;
  logic [SpriW-1:0]  o_prio;
  logic [CountW-1:0] o_n;

  assign o_bonus = m_axis_tdata_o[QuantW+TimeW+CountW +: BonusW];
  assign o_prio  = m_axis_tdata_o[OutW-1 -: SpriW];
  assign o_n     = m_axis_tdata_o[QuantW+TimeW +: CountW];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result beat dropped while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result beat changed while stalled");

  a_skid_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> $past(m_axis_tvalid_o && !m_axis_tready_i))
    else $error("input held off without an output stall");

  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (o_bonus <= BonusMax) && (o_prio >= PrioMin) &&
                        (o_prio <= PrioMax) && (o_n != '0))
    else $error("result fields out of range");

endmodule

bind dynamic_priority_update dpu_checker u_dpu_checker (.*);
